// ----- design/bdht_pkg.sv -----
// ----------------------------------------------------------------------------
// bdht_pkg
// Types, constants and helpers shared by the button debounce / hold timer.
// ----------------------------------------------------------------------------
package bdht_pkg;

  localparam int BUTTON_COUNT_DEF = 4;
  localparam int NUM_SLOTS        = 4;

  localparam int SETTLE_TIME_W = 10;
  localparam int TICK_STEP_W   = 7;
  localparam int SETTLE_CNT_W  = 11;
  localparam int HOLD_W        = 24;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 10;

  localparam logic [SETTLE_TIME_W-1:0] SETTLE_TIME_RST = SETTLE_TIME_W'(50);
  localparam logic [TICK_STEP_W-1:0]   TICK_STEP_RST   = TICK_STEP_W'(10);

  localparam logic [HOLD_W-1:0]       HOLD_MAX   = {HOLD_W{1'b1}};
  localparam logic [SETTLE_CNT_W-1:0] SETTLE_MAX = {SETTLE_CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TIME = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP   = 2'd1;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // reported state codes
  localparam logic [1:0] CODE_RELEASED         = 2'd0;
  localparam logic [1:0] CODE_PRESS_SETTLING   = 2'd1;
  localparam logic [1:0] CODE_PRESSED          = 2'd2;
  localparam logic [1:0] CODE_RELEASE_SETTLING = 2'd3;

  typedef enum logic [3:0] {
    ST_RELEASED         = 4'b0001,
    ST_PRESS_SETTLING   = 4'b0010,
    ST_PRESSED          = 4'b0100,
    ST_RELEASE_SETTLING = 4'b1000
  } btn_state_t;

  typedef struct packed {
    logic       command;
    logic [1:0] button_index;
    logic [3:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        state_zero;
    logic [1:0]        state_one;
    logic [1:0]        state_two;
    logic [1:0]        state_three;
    logic [HOLD_W-1:0] hold_zero;
    logic [HOLD_W-1:0] hold_one;
    logic [HOLD_W-1:0] hold_two;
    logic [HOLD_W-1:0] hold_three;
  } out_item_t;

  // per-lane request from the dispatch logic
  typedef struct packed {
    logic en;
    logic tick;
    logic edge_hit;
    logic pin;
  } lane_cmd_t;

  // per-lane status after the request
  typedef struct packed {
    logic [1:0]        state;
    logic [HOLD_W-1:0] hold;
  } lane_status_t;

  function automatic logic [1:0] state_code(input btn_state_t s);
    logic [1:0] c;
    case (s)
      ST_RELEASED:         c = CODE_RELEASED;
      ST_PRESS_SETTLING:   c = CODE_PRESS_SETTLING;
      ST_PRESSED:          c = CODE_PRESSED;
      ST_RELEASE_SETTLING: c = CODE_RELEASE_SETTLING;
      default:             c = CODE_RELEASED;
    endcase
    return c;
  endfunction

endpackage

// ----- design/bdht_lane.sv -----
// ----------------------------------------------------------------------------
// bdht_lane
// Debounce state, settle counter and hold timer of one button.
// ----------------------------------------------------------------------------
module bdht_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdht_pkg::lane_cmd_t                  cmd,
  input  logic [bdht_pkg::SETTLE_TIME_W-1:0]   settle_time,
  input  logic [bdht_pkg::TICK_STEP_W-1:0]     tick_step,
  output bdht_pkg::lane_status_t               status
);
  import bdht_pkg::*;

  btn_state_t              state;
  btn_state_t              state_next;
  logic [SETTLE_CNT_W-1:0] count;
  logic [SETTLE_CNT_W-1:0] count_next;
  logic [HOLD_W-1:0]       hold;
  logic [HOLD_W-1:0]       hold_next;

  logic [SETTLE_CNT_W:0]   count_sum;
  logic [HOLD_W:0]         hold_sum;
  logic                    settled;

  assign count_sum = {1'b0, count} + (SETTLE_CNT_W+1)'(tick_step);
  assign hold_sum  = {1'b0, hold} + (HOLD_W+1)'(tick_step);
  assign settled   = count >= SETTLE_CNT_W'(settle_time);

  always_comb begin
    state_next = state;
    count_next = count;
    hold_next  = hold;
    if (cmd.edge_hit) begin
      case (state)
        ST_RELEASED: begin
          state_next = ST_PRESS_SETTLING;
          hold_next  = '0;
        end
        ST_PRESSED: begin
          state_next = ST_RELEASE_SETTLING;
        end
        default: ;
      endcase
    end else if (cmd.tick) begin
      case (state)
        ST_PRESSED: begin
          hold_next = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
        end
        ST_PRESS_SETTLING, ST_RELEASE_SETTLING: begin
          if (settled) begin
            state_next = cmd.pin ? ST_PRESSED : ST_RELEASED;
            count_next = '0;
          end else begin
            count_next = count_sum[SETTLE_CNT_W] ? SETTLE_MAX
                                                 : count_sum[SETTLE_CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RELEASED;
      count <= '0;
      hold  <= '0;
    end else if (cmd.en) begin
      state <= state_next;
      count <= count_next;
      hold  <= hold_next;
    end
  end

  // report the values this request leaves behind
  assign status.state = state_code(state_next);
  assign status.hold  = hold_next;

endmodule

// ----- design/bdht_merge.sv -----
// ----------------------------------------------------------------------------
// bdht_merge
// Gathers the lane results into one result item; unused slots read zero.
// ----------------------------------------------------------------------------
module bdht_merge #(
  parameter int BUTTON_COUNT = bdht_pkg::BUTTON_COUNT_DEF
) (
  input  bdht_pkg::lane_status_t lanes [BUTTON_COUNT],
  output bdht_pkg::out_item_t    result
);
  import bdht_pkg::*;

  lane_status_t slots [NUM_SLOTS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i < BUTTON_COUNT) begin : g_used
      assign slots[i] = lanes[i];
    end else begin : g_unused
      assign slots[i] = '0;
    end
  end

  assign result.state_zero  = slots[0].state;
  assign result.state_one   = slots[1].state;
  assign result.state_two   = slots[2].state;
  assign result.state_three = slots[3].state;
  assign result.hold_zero   = slots[0].hold;
  assign result.hold_one    = slots[1].hold;
  assign result.hold_two    = slots[2].hold;
  assign result.hold_three  = slots[3].hold;

endmodule

// ----- design/button_debounce_hold_timer_top.sv -----
// ----------------------------------------------------------------------------
// button_debounce_hold_timer_top
// Four-button debouncer with per-button hold timers, one lane per button.
// ----------------------------------------------------------------------------
// channel   | signals                                 | direction
// ----------+-----------------------------------------+----------
// in        | in_valid, in_stall, in_data             | request in
// out       | out_valid, out_stall, out_data          | result out
// cfg       | cfg_write, cfg_index, cfg_data          | write only
//
// one request per cycle while in_stall is low; every lane updates in the
// accept cycle and the result is registered, into the output register or,
// if that holds an untaken result, into the skid entry. a two-entry output
// (register plus skid) keeps accepting while one result waits; in_stall
// rises only when both entries are full. reset returns all buttons to
// released with zero counters, settle_time 50, tick_step 10.
module button_debounce_hold_timer_top #(
  parameter int BUTTON_COUNT = bdht_pkg::BUTTON_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bdht_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bdht_pkg::out_item_t                out_data,
  input  logic                               cfg_write,
  input  logic [bdht_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdht_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bdht_pkg::*;

  logic [SETTLE_TIME_W-1:0] settle_time;
  logic [TICK_STEP_W-1:0]   tick_step;

  logic         accept;
  logic         take;
  logic         skid_valid;
  out_item_t    skid_data;
  out_item_t    result;
  lane_cmd_t    cmds  [BUTTON_COUNT];
  lane_status_t lanes [BUTTON_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_time <= SETTLE_TIME_RST;
      tick_step   <= TICK_STEP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETTLE_TIME: settle_time <= cfg_data;
        REG_TICK_STEP:   tick_step   <= cfg_data[TICK_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    assign cmds[i].en       = accept;
    assign cmds[i].tick     = in_data.command == CMD_TICK;
    assign cmds[i].edge_hit = (in_data.command == CMD_EDGE)
                              && (in_data.button_index == 2'(i));
    assign cmds[i].pin      = in_data.pin_levels[i];

    bdht_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmds[i]),
      .settle_time (settle_time),
      .tick_step   (tick_step),
      .status      (lanes[i])
    );
  end

  bdht_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .lanes  (lanes),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_blocked_goes_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> skid_valid)
    else $error("request accepted behind a stalled result was not held");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (take && !skid_valid && !accept) |=> !out_valid)
    else $error("output still valid after its only result was taken");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && take) |=> (out_valid && !skid_valid))
    else $error("skid entry did not move to the output");

endmodule
